@@ hw/rtl/hrde_pkg.sv @@
// Shared constants, types and the hex digit decoder for the hex record data extractor.
package hrde_pkg;

  localparam int unsigned CharW          = 8;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned IndexW         = 16;
  localparam int unsigned DigitW         = 5;
  localparam int unsigned CountW         = 8;
  localparam int unsigned LineColumnsDef = 1024;

  localparam logic [IndexW-1:0] ByteLimitRst = 16'd4400;
  localparam logic [CharW-1:0]  CharNewline  = 8'd10;

  // fixed column positions within a record line
  localparam int unsigned ColCountHi = 1;
  localparam int unsigned ColCountLo = 2;
  localparam int unsigned ColTypeHi  = 7;
  localparam int unsigned ColTypeLo  = 8;
  localparam int unsigned ColData    = 9;
  localparam int unsigned ColPair0   = 10;

  typedef logic signed [DigitW-1:0] digit_t;
  typedef logic [CharW-1:0]         char_t;
  typedef logic [ByteW-1:0]         byte_t;
  typedef logic [IndexW-1:0]        index_t;
  typedef logic [CountW-1:0]        count_t;

  // 0..15 for a hex character, -1 otherwise
  function automatic digit_t hex_value(input char_t ch);
    digit_t v;
    case (ch) inside
      ["0":"9"]: v = digit_t'(ch - "0");
      ["a":"f"]: v = digit_t'(ch - "a" + 8'd10);
      ["A":"F"]: v = digit_t'(ch - "A" + 8'd10);
      default:   v = '1;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/hrde_char_if.sv @@
// Character channel: one text character per beat.
interface hrde_char_if;
  logic                valid;
  logic                ready;
  hrde_pkg::char_t     text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

@@ hw/rtl/hrde_byte_if.sv @@
// Result channel: one decoded data byte with its buffer index per beat.
interface hrde_byte_if;
  logic                valid;
  logic                ready;
  hrde_pkg::byte_t     data_byte;
  hrde_pkg::index_t    byte_index;
  logic                last_byte;

  modport source (output valid, output data_byte, output byte_index, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_index, input last_byte,
                  output ready);
endinterface

@@ hw/rtl/hex_record_data_extractor.sv @@
// Top level: extracts data record bytes from a stream of hex text characters.
//
//   channel   dir  payload                              handshake
//   text_i    in   text_char[7:0]                       valid/ready
//   byte_o    out  data_byte[7:0] byte_index[15:0] last valid/ready
//   cfg       in   cfg_wdata_i[15:0] (byte_limit)       cfg_we_i, no stall
//
// One character per cycle unless stalled; a byte is registered as its second digit is used.
// Input register then result register; the column/state update sits between them.
// Reset clears control state (not data registers), sets byte_limit to 4400; no clearing pass.
// A stalled result holds the input register, which takes one more beat and then drops ready.
// After the byte that reaches the limit, all further characters are dropped until reset.
module hex_record_data_extractor #(
  parameter int unsigned LINE_COLUMNS = hrde_pkg::LineColumnsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  hrde_pkg::index_t       cfg_wdata_i,
  hrde_char_if.sink              text_i,
  hrde_byte_if.source            byte_o
);
  import hrde_pkg::*;

  localparam int unsigned ColW = $clog2(LINE_COLUMNS + 1);
  typedef logic [ColW-1:0] col_t;

  logic   in_vld_q;
  char_t  char_q;
  logic   out_vld_q;
  byte_t  data_q;
  index_t index_q;
  logic   last_q;

  col_t   col_q, col_d;
  digit_t hi_q, hi_d;
  count_t cnt_q, cnt_d;
  logic   tyhz_q, tyhz_d;
  logic   tyd_q, tyd_d;
  index_t idx_q, idx_d;
  logic   fin_q, fin_d;
  index_t limit_q;

  logic              adv, step;
  digit_t            dig;
  logic signed [9:0] pair;
  col_t              pair_k;
  logic              emit, last;

  assign adv          = !out_vld_q || byte_o.ready;
  assign step         = in_vld_q && adv;
  assign text_i.ready = !in_vld_q || adv;

  assign dig    = hex_value(char_q);
  assign pair   = {hi_q[DigitW-1], hi_q, 4'b0000} + {{5{dig[DigitW-1]}}, dig};
  assign pair_k = col_t'(col_q - col_t'(ColPair0)) >> 1;
  assign last   = ({1'b0, idx_q} + 17'd1) >= {1'b0, limit_q};

  always_comb begin
    col_d  = col_q;
    hi_d   = hi_q;
    cnt_d  = cnt_q;
    tyhz_d = tyhz_q;
    tyd_d  = tyd_q;
    idx_d  = idx_q;
    fin_d  = fin_q;
    emit   = 1'b0;
    if (step && !fin_q) begin
      if (char_q == CharNewline) begin
        col_d  = '0;
        cnt_d  = '0;
        tyhz_d = 1'b0;
        tyd_d  = 1'b0;
      end else begin
        if (col_q == col_t'(ColCountHi)) begin
          hi_d = dig;
        end else if (col_q == col_t'(ColCountLo)) begin
          cnt_d = pair[9] ? '0 : pair[CountW-1:0];
        end else if (col_q == col_t'(ColTypeHi)) begin
          tyhz_d = (dig == '0);
        end else if (col_q == col_t'(ColTypeLo)) begin
          tyd_d = tyhz_q && (dig == '0);
        end else if (col_q >= col_t'(ColData)) begin
          if (col_q[0]) begin
            hi_d = dig;
          end else if (tyd_q && (pair_k < col_t'(cnt_q))) begin
            emit  = 1'b1;
            idx_d = idx_q + 16'd1;
            fin_d = last;
          end
        end
        if (col_q < col_t'(LINE_COLUMNS)) begin
          col_d = col_q + col_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      col_q     <= '0;
      hi_q      <= '0;
      cnt_q     <= '0;
      tyhz_q    <= 1'b0;
      tyd_q     <= 1'b0;
      idx_q     <= '0;
      fin_q     <= 1'b0;
      limit_q   <= ByteLimitRst;
    end else begin
      if (text_i.ready) begin
        in_vld_q <= text_i.valid;
      end
      if (adv) begin
        out_vld_q <= emit;
      end
      col_q  <= col_d;
      hi_q   <= hi_d;
      cnt_q  <= cnt_d;
      tyhz_q <= tyhz_d;
      tyd_q  <= tyd_d;
      idx_q  <= idx_d;
      fin_q  <= fin_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      char_q <= text_i.text_char;
    end
    if (emit) begin
      data_q  <= pair[ByteW-1:0];
      index_q <= idx_q;
      last_q  <= last;
    end
  end

  assign byte_o.valid      = out_vld_q;
  assign byte_o.data_byte  = data_q;
  assign byte_o.byte_index = index_q;
  assign byte_o.last_byte  = last_q;

endmodule

@@ hw/rtl/hrde_checker.sv @@
// Port-level checks for the hex record data extractor, bound to the top level.
module hrde_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input hrde_pkg::index_t cfg_wdata_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input hrde_pkg::byte_t  out_data_i,
  input hrde_pkg::index_t out_index_i,
  input logic             out_last_i
);
  import hrde_pkg::*;

  index_t exp_idx_q;
  index_t limit_q;
  logic   done_q;
  logic   beat;

  assign beat = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
      limit_q   <= ByteLimitRst;
      done_q    <= 1'b0;
    end else begin
      if (beat) begin
        exp_idx_q <= out_index_i + 16'd1;
        done_q    <= done_q || out_last_i;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat |-> out_index_i == exp_idx_q)
    else $error("byte index out of sequence");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat |-> out_last_i == (({1'b0, out_index_i} + 17'd1) >= {1'b0, limit_q}))
    else $error("last flag disagrees with limit");

  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !out_valid_i)
    else $error("beat after last byte");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_data_i) && $stable(out_index_i) && $stable(out_last_i))
    else $error("stalled result changed");

endmodule

bind hex_record_data_extractor hrde_checker u_hrde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .out_data_i  (byte_o.data_byte),
  .out_index_i (byte_o.byte_index),
  .out_last_i  (byte_o.last_byte)
);

@@ tb/tb.sv @@
// Testbench for hex_record_data_extractor: random and directed hex text checked against a predictor.
module tb;
  import hrde_pkg::*;

  localparam int unsigned LineCols = LineColumnsDef;

  typedef struct packed {
    byte_t  data;
    index_t idx;
    logic   last;
  } extracted_byte_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   cfg_we_i;
  index_t cfg_wdata_i;

  hrde_char_if text_if ();
  hrde_byte_if byte_if ();

  hex_record_data_extractor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .text_i      (text_if),
    .byte_o      (byte_if)
  );

  char_t           char_stream_q[$];
  extracted_byte_t expected_bytes_q[$];
  extracted_byte_t got_byte;
  int              fail_count = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  logic            hold_go = 1'b0;
  int              hold_left;

  // predictor state
  int unsigned ext_column;
  digit_t      ext_high;
  int          ext_count;
  logic        ext_type_hi0;
  logic        ext_is_data;
  index_t      ext_index;
  logic        ext_done;
  index_t      ext_limit;

  initial begin
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    text_if.valid = 1'b0;
    text_if.text_char = '0;
    byte_if.ready = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic digit_t nibble_of(input char_t ch);
    if (ch >= "0" && ch <= "9") return digit_t'(ch - "0");
    if (ch >= "a" && ch <= "f") return digit_t'(ch - "a" + 8'd10);
    if (ch >= "A" && ch <= "F") return digit_t'(ch - "A" + 8'd10);
    return digit_t'(-1);
  endfunction

  function automatic void take_char(input char_t ch);
    digit_t          d;
    int unsigned     col;
    int              val;
    extracted_byte_t b;
    col = ext_column;
    if (ext_done) return;
    if (ch == CharNewline) begin
      ext_column = 0;
      ext_count = 0;
      ext_type_hi0 = 1'b0;
      ext_is_data = 1'b0;
      return;
    end
    d = nibble_of(ch);
    if (col == ColCountHi) begin
      ext_high = d;
    end else if (col == ColCountLo) begin
      val = int'(ext_high) * 16 + int'(d);
      ext_count = (val < 0) ? 0 : val;
    end else if (col == ColTypeHi) begin
      ext_type_hi0 = (d == 0);
    end else if (col == ColTypeLo) begin
      ext_is_data = ext_type_hi0 && (d == 0);
    end else if (col >= ColData) begin
      if (col % 2 == 1) begin
        ext_high = d;
      end else if (ext_is_data && ((col - ColPair0) >> 1) < ext_count) begin
        val = int'(ext_high) * 16 + int'(d);
        b.data = val[7:0];
        b.idx = ext_index;
        b.last = ({1'b0, ext_index} + 17'd1) >= {1'b0, ext_limit};
        expected_bytes_q.push_back(b);
        ext_index = ext_index + 1'b1;
        if (b.last) ext_done = 1'b1;
      end
    end
    if (col < LineCols) ext_column = col + 1;
  endfunction

  // character driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_if.valid <= 1'b0;
    end else if (!text_if.valid || text_if.ready) begin
      if (char_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        text_if.valid <= 1'b1;
        text_if.text_char <= char_stream_q.pop_front();
      end else begin
        text_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && text_if.valid && text_if.ready) take_char(text_if.text_char);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.ready <= 1'b0;
    end else begin
      byte_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (expected_bytes_q.size() == 0) begin
        $error("unexpected beat: data_byte %0h byte_index %0d last_byte %0b",
               byte_if.data_byte, byte_if.byte_index, byte_if.last_byte);
        fail_count++;
      end else begin
        got_byte = expected_bytes_q.pop_front();
        if (byte_if.data_byte !== got_byte.data) begin
          $error("data_byte: expected %0h, got %0h", got_byte.data, byte_if.data_byte);
          fail_count++;
        end
        if (byte_if.byte_index !== got_byte.idx) begin
          $error("byte_index: expected %0d, got %0d", got_byte.idx, byte_if.byte_index);
          fail_count++;
        end
        if (byte_if.last_byte !== got_byte.last) begin
          $error("last_byte: expected %0b, got %0b", got_byte.last, byte_if.last_byte);
          fail_count++;
        end
      end
    end
  end

  function automatic char_t hex_char(input int v);
    if (v < 10) return char_t'(8'h30 + v);
    return char_t'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic char_t junk_char();
    char_t c;
    do c = char_t'($urandom_range(255));
    while (nibble_of(c) >= 0 || c == CharNewline);
    return c;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) char_stream_q.push_back(char_t'(s[i]));
  endtask

  task automatic push_hex2(input int v);
    char_stream_q.push_back(hex_char((v >> 4) & 15));
    char_stream_q.push_back(hex_char(v & 15));
  endtask

  // rtype < 0 gives a type field with a non-hex digit
  task automatic add_record(input int count, input int rtype, input bit corrupt, input bit trunc);
    int start;
    int len;
    start = char_stream_q.size();
    char_stream_q.push_back(":");
    if (corrupt && $urandom_range(3) == 0) begin
      char_stream_q.push_back(junk_char());
      char_stream_q.push_back(hex_char(count & 15));
    end else begin
      push_hex2(count);
    end
    push_hex2($urandom_range(255));
    push_hex2($urandom_range(255));
    if (rtype < 0) begin
      char_stream_q.push_back("0");
      char_stream_q.push_back(junk_char());
    end else begin
      push_hex2(rtype);
    end
    for (int i = 0; i < 2 * count; i++) begin
      if (corrupt && $urandom_range(7) == 0) char_stream_q.push_back(junk_char());
      else char_stream_q.push_back(hex_char($urandom_range(15)));
    end
    push_hex2($urandom_range(255));
    if (trunc) begin
      len = char_stream_q.size() - start;
      repeat ($urandom_range(1, len - 1)) void'(char_stream_q.pop_back());
    end
    char_stream_q.push_back(CharNewline);
  endtask

  task automatic fill_random(input int n_chars);
    int start;
    int r;
    int cnt;
    start = char_stream_q.size();
    while (char_stream_q.size() - start < n_chars) begin
      r = $urandom_range(99);
      cnt = ($urandom_range(19) == 0) ? $urandom_range(17, 255) : $urandom_range(16);
      if (r < 65) begin
        add_record(cnt, 0, $urandom_range(9) == 0, $urandom_range(7) == 0);
      end else if (r < 80) begin
        add_record($urandom_range(16), ($urandom_range(3) == 0) ? -1 : $urandom_range(1, 255),
                   1'b0, $urandom_range(7) == 0);
      end else begin
        repeat ($urandom_range(1, 24)) char_stream_q.push_back(char_t'($urandom_range(255)));
        char_stream_q.push_back(CharNewline);
      end
    end
  endtask

  task automatic write_limit(input index_t v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    ext_limit = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idle(input int s, input int r);
    @(negedge clk_i);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (char_stream_q.size() != 0 || text_if.valid || expected_bytes_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    ext_column = 0;
    ext_high = '0;
    ext_count = 0;
    ext_type_hi0 = 1'b0;
    ext_is_data = 1'b0;
    ext_index = '0;
    ext_done = 1'b0;
    ext_limit = ByteLimitRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_limit(16'hFFFF);

    // directed: both digit cases, non-hex data digit, pairs past the count,
    // extreme chars, non-data type, short line
    set_idle(0, 0);
    push_text(":02ABCD00fFg012\n");
    char_stream_q.push_back(8'h00);
    char_stream_q.push_back("1");
    char_stream_q.push_back(8'hFF);
    push_text("00000112\n:0\n");
    wait_idle();

    write_limit(index_t'($urandom_range(5000, 65000)));
    set_idle(84, 0);
    fill_random(180);
    wait_idle();

    set_idle(0, 84);
    fill_random(180);
    wait_idle();

    write_limit(index_t'($urandom_range(5000, 65000)));
    set_idle(34, 34);
    // line well past the column limit, all hex
    push_text(":FF000000");
    repeat (1100) char_stream_q.push_back(hex_char($urandom_range(15)));
    char_stream_q.push_back(CharNewline);
    fill_random(100);
    wait_idle();

    // long receiver hold-off so the block backs up
    set_idle(0, 0);
    hold_go = 1'b1;
    fill_random(180);
    @(negedge clk_i);
    hold_go = 1'b0;
    wait_idle();

    // limit below the running index: next beat is last, rest dropped
    write_limit(16'd1);
    set_idle(34, 34);
    fill_random(80);
    wait_idle();
    repeat (12) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/hrde_pkg.sv
hw/rtl/hrde_char_if.sv
hw/rtl/hrde_byte_if.sv
hw/rtl/hex_record_data_extractor.sv
hw/rtl/hrde_checker.sv
tb/tb.sv
